FILE: rtl/rmst_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// range-maximum segment tree. Depends on nothing; every other file but rmst_ram uses it.
package rmst_pkg;

	// Tree geometry and field widths.
	localparam int LEAF_COUNT = 1024;
	localparam int LEAF_W     = $clog2(LEAF_COUNT);
	localparam int NODE_COUNT = 2 * LEAF_COUNT;
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int WALK_W     = NODE_W + 1;
	localparam int VAL_W      = 31;

	// Packed channel widths.
	localparam int IN_DATA_W  = 64;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 32;

	// Operation carried in tuser.
	typedef enum logic [0:0] {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_LD_WR,
		ST_LD_RD,
		ST_LD_UP,
		ST_Q_A,
		ST_Q_B,
		ST_Q_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic clr;
		logic ld_start;
		logic ld_rd;
		logic ld_up;
		logic q_init;
		logic q_a;
		logic q_b;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_query;
		logic node_root;
		logic q_empty;
		logic walk_done;
		logic clr_last;
		logic out_free;
	} stat_t;

endpackage

FILE: rtl/range_max_segment_tree_top.sv
// Top level of the range-maximum segment tree: controller plus datapath.
// Depends on rmst_pkg, rmst_ctrl, rmst_dp (and rmst_ram below it).
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid / s_tready  op in tuser, leaf and range fields in tdata
//   m_*       out        m_tvalid / m_tready  max_value in tdata
//   cfg_*     in         cfg_valid/cfg_ready  last_index
//
// After reset all 2048 node store entries are cleared one entry a cycle, and no
// item is taken meanwhile; configuration writes are taken at any time.
// A load or a query makes two accesses per tree level on the single-port node
// memory. One item is in work at a time. A result waiting in the output register
// does not stop the next item from being taken, but the result of a later query
// waits in ST_Q_OUT until the pending result is taken.
module range_max_segment_tree_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [9:0] leaf_index, [40:10] leaf_value, [50:41] range_low,
	// [60:51] range_high, [63:61] zero
	input  logic [rmst_pkg::IN_DATA_W-1:0]  s_tdata,
	// [0] op
	input  logic [rmst_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [30:0] max_value, [31] zero
	output logic [rmst_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rmst_pkg::LEAF_W-1:0]     cfg_data
);

	rmst_pkg::cmd_t  cmd;
	rmst_pkg::stat_t stat;

	// Sequencer.
	rmst_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// Storage and arithmetic.
	rmst_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

FILE: rtl/rmst_ram.sv
// Generic single-port RAM with a registered read port.
// Self-contained; used for the tree node store.
module rmst_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One access per cycle; read data appears after the clock edge.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: rtl/rmst_ctrl.sv
// Sequencer for the range-maximum segment tree: clearing pass, leaf loads
// and range walks. Depends on rmst_pkg for states, commands and status.
module rmst_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  rmst_pkg::stat_t stat,
	output rmst_pkg::cmd_t  cmd
);

	rmst_pkg::state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmst_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = (state_q == rmst_pkg::ST_IDLE);
		unique case (state_q)
			rmst_pkg::ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) begin
					state_d = rmst_pkg::ST_IDLE;
				end
			end
			rmst_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = rmst_pkg::ST_DECODE;
				end
			end
			rmst_pkg::ST_DECODE: begin
				if (stat.is_query) begin
					cmd.q_init = 1'b1;
					state_d    = stat.q_empty ? rmst_pkg::ST_Q_OUT : rmst_pkg::ST_Q_A;
				end else begin
					state_d = rmst_pkg::ST_LD_WR;
				end
			end
			rmst_pkg::ST_LD_WR: begin
				cmd.ld_start = 1'b1;
				state_d      = rmst_pkg::ST_LD_RD;
			end
			rmst_pkg::ST_LD_RD: begin
				if (stat.node_root) begin
					state_d = rmst_pkg::ST_IDLE;
				end else begin
					cmd.ld_rd = 1'b1;
					state_d   = rmst_pkg::ST_LD_UP;
				end
			end
			rmst_pkg::ST_LD_UP: begin
				cmd.ld_up = 1'b1;
				state_d   = rmst_pkg::ST_LD_RD;
			end
			rmst_pkg::ST_Q_A: begin
				if (stat.walk_done) begin
					state_d = rmst_pkg::ST_Q_OUT;
				end else begin
					cmd.q_a = 1'b1;
					state_d = rmst_pkg::ST_Q_B;
				end
			end
			rmst_pkg::ST_Q_B: begin
				cmd.q_b = 1'b1;
				state_d = rmst_pkg::ST_Q_A;
			end
			rmst_pkg::ST_Q_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = rmst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rmst_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/rmst_dp.sv
// Datapath of the range-maximum segment tree: item registers, node store
// port mux, walk pointers, running maximum and result register.
// Depends on rmst_pkg and rmst_ram.
module rmst_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rmst_pkg::cmd_t                     cmd,
	output rmst_pkg::stat_t                    stat,
	input  logic [rmst_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic [rmst_pkg::IN_USER_W-1:0]     s_tuser,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rmst_pkg::LEAF_W-1:0]        cfg_data,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [rmst_pkg::OUT_DATA_W-1:0]    m_tdata
);

	localparam int LW = rmst_pkg::LEAF_W;
	localparam int NW = rmst_pkg::NODE_W;
	localparam int WW = rmst_pkg::WALK_W;
	localparam int VW = rmst_pkg::VAL_W;

	logic [LW-1:0] last_index_q;
	rmst_pkg::op_t op_q;
	logic [LW-1:0] idx_q, lo_q, hi_q;
	logic [VW-1:0] val_q, carry_q, best_q, out_data_q;
	logic [NW-1:0] node_q, clr_cnt_q, leaf_node;
	logic [WW-1:0] a_q, b_q, b_minus;
	logic          fold_q, out_valid_q;
	logic [LW-1:0] hi_clamp;
	logic [VW-1:0] up_max, rdata, wdata;
	logic [NW-1:0] addr;
	logic          we;

	// Configuration register; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_index_q <= LW'(rmst_pkg::LEAF_COUNT - 1);
		end else if (cfg_valid) begin
			last_index_q <= cfg_data;
		end
	end

	// Input item registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= rmst_pkg::op_t'(s_tuser[0]);
			idx_q <= s_tdata[LW-1:0];
			val_q <= s_tdata[LW+VW-1:LW];
			lo_q  <= s_tdata[2*LW+VW-1:LW+VW];
			hi_q  <= s_tdata[3*LW+VW-1:2*LW+VW];
		end
	end

	// Bound clamping and derived indices.
	assign hi_clamp  = (hi_q > last_index_q) ? last_index_q : hi_q;
	assign leaf_node = NW'(rmst_pkg::LEAF_COUNT) + NW'(idx_q);
	assign b_minus   = b_q - WW'(1);
	assign up_max    = (rdata > carry_q) ? rdata : carry_q;

	// Node store port selection.
	always_comb begin
		we    = 1'b0;
		addr  = node_q;
		wdata = '0;
		if (cmd.clr) begin
			we   = 1'b1;
			addr = clr_cnt_q;
		end else if (cmd.ld_start) begin
			we    = 1'b1;
			addr  = leaf_node;
			wdata = val_q;
		end else if (cmd.ld_rd) begin
			addr = node_q ^ NW'(1);
		end else if (cmd.ld_up) begin
			we    = 1'b1;
			addr  = node_q >> 1;
			wdata = up_max;
		end else if (cmd.q_a) begin
			addr = a_q[NW-1:0];
		end else if (cmd.q_b) begin
			addr = b_minus[NW-1:0];
		end
	end

	rmst_ram #(
		.WIDTH(VW),
		.DEPTH(rmst_pkg::NODE_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.addr (addr),
		.wdata(wdata),
		.rdata(rdata)
	);

	// Clearing pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + NW'(1);
		end
	end

	// Load walk: current node and the maximum carried upward.
	always_ff @(posedge clk) begin
		if (cmd.ld_start) begin
			node_q  <= leaf_node;
			carry_q <= val_q;
		end else if (cmd.ld_up) begin
			node_q  <= node_q >> 1;
			carry_q <= up_max;
		end
	end

	// Query walk pointers over the half-open node range [a, b).
	always_ff @(posedge clk) begin
		if (cmd.q_init) begin
			a_q <= WW'(rmst_pkg::LEAF_COUNT) + WW'(lo_q);
			b_q <= WW'(rmst_pkg::LEAF_COUNT) + WW'(hi_clamp) + WW'(1);
		end else if (cmd.q_a) begin
			if (a_q[0]) begin
				a_q <= a_q + WW'(1);
			end
		end else if (cmd.q_b) begin
			a_q <= a_q >> 1;
			b_q <= (b_q[0] ? b_minus : b_q) >> 1;
		end
	end

	// A read issued for the query folds into the maximum in the following cycle, when its data is back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_q <= 1'b0;
		end else begin
			fold_q <= (cmd.q_a & a_q[0]) | (cmd.q_b & b_q[0]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.q_init) begin
			best_q <= '0;
		end else if (fold_q && (rdata > best_q)) begin
			best_q <= rdata;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= best_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(rmst_pkg::OUT_DATA_W - VW){1'b0}}, out_data_q};

	// Status back to the controller.
	assign stat.is_query  = (op_q == rmst_pkg::OP_QUERY);
	assign stat.node_root = (node_q == NW'(1));
	assign stat.q_empty   = (lo_q > hi_clamp);
	assign stat.walk_done = (a_q >= b_q);
	assign stat.clr_last  = &clr_cnt_q;
	assign stat.out_free  = !out_valid_q || m_tready;

`ifndef SYNTHESIS
	// The walk never crosses its bounds while it is reading.
	a_walk_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.q_a || cmd.q_b) |-> (a_q <= b_q))
		else $error("query walk pointers crossed");

	// A load never climbs past the root.
	a_load_node: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ld_rd || cmd.ld_up) |-> (node_q > NW'(1)))
		else $error("load walk passed the root");

	// A finished result never overwrites one that was not taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || m_tready))
		else $error("pending result overwritten");

	// A fold only consumes data from a read cycle, never a write cycle.
	a_fold_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		fold_q |-> ($past(cmd.q_a) || $past(cmd.q_b)))
		else $error("fold without a preceding query read");
`endif

endmodule
